/* src/dotq_pkg.sv */
// Shared types and constants for the deadline-ordered timer queue.
// Used by the top level; depends on nothing.
`default_nettype none
package dotq_pkg;

  // Slot pool size and derived widths.
  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LINK_W      = 6;
  localparam logic [LINK_W-1:0] NULL_LINK = '1;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_POST = 2'd0,
    OP_HOST = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result kinds.
  typedef enum logic [2:0] {
    RK_POSTED  = 3'd0,
    RK_DROPPED = 3'd1,
    RK_FIRED   = 3'd2,
    RK_EXPIRED = 3'd3,
    RK_STATUS  = 3'd4
  } kind_t;

  // One slot word in the slot RAM.
  typedef struct packed {
    logic [63:0]       deadline;
    logic [7:0]        handle;
    logic [LINK_W-1:0] link;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_P_FREE_RD, ST_P_FREE, ST_P_RD, ST_P_CMP, ST_P_INS, ST_P_LNK,
    ST_T_RD, ST_T_CMP, ST_WAKE, ST_O_HOST, ST_E_RD, ST_E_OUT, ST_O_FINAL
  } state_t;

  // Link a slot holds before it is first written: the chained free list.
  function automatic logic [LINK_W-1:0] def_link(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] res;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      res = NULL_LINK;
    end else begin
      res = LINK_W'(idx) + LINK_W'(1);
    end
    return res;
  endfunction

  function automatic logic slot_ok(input logic [LINK_W-1:0] s);
    return s < LINK_W'(QUEUE_DEPTH);
  endfunction

endpackage
`default_nettype wire

/* src/dotq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the slot words of the timer queue.
`default_nettype none
module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/deadline_ordered_timer_queue_unit.sv */
// Top level of the deadline-ordered timer queue: sequencer, list walker and result port.
// Depends on dotq_pkg and dotq_ram.
`default_nettype none
// The block takes one request at a time and is not ready until its last result
// is taken. Slot words live in one RAM with a registered read port, so every
// slot visited in a list walk takes a read state and a compare state. A post
// walks the queue past the tasks at or before its deadline, writes the new slot
// and, when it lands behind the head, relinks the slot before it; a post with no
// free slot is dropped. A tick walks the expired tasks, then sends the host
// result when the host deadline fires and one result per expired task; each
// expired slot is read from the RAM before its result is shown, and the next is
// read only after that result is taken. All results of a request carry the wake
// deadline computed after the request.
module deadline_ordered_timer_queue_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation[1:0], now_us[65:2], delay_us[107:66], task_id[115:108],
  // host_deadline_ms[159:116]
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // task_id_out[7:0], wake_deadline_us[71:8], wake_changed[72], pending[73]
  output logic [79:0]       out_tdata,
  // result_kind[2:0]
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);
  import dotq_pkg::*;

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [63:0]       dl_r, dl_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [LINK_W-1:0] qhead_r, qhead_nxt, fhead_r, fhead_nxt;
  logic [63:0]       host_r, host_nxt, armed_r, armed_nxt;
  logic [63:0]       head_dl_r, head_dl_nxt, wake_r, wake_nxt;
  logic              chg_r, chg_nxt, pend_r, pend_nxt, fired_r, fired_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, slot_r, slot_nxt;
  logic [LINK_W-1:0] pop_r, pop_nxt;
  logic [63:0]       pdl_r, pdl_nxt;
  logic [7:0]        phd_r, phd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  kind_t             kind_r, kind_nxt;
  logic [QUEUE_DEPTH-1:0] vld_r, vld_nxt;
  logic              rvld_r;
  logic [IDX_W-1:0]  ridx_r;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  slot_t             wdata, rdata;
  logic [SLOT_W-1:0] rdata_raw;
  logic [LINK_W-1:0] rd_link;
  logic [64:0]       sum;
  logic [63:0]       wake_c;
  logic              in_acc, out_acc;

  // Slot storage.
  dotq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata   = slot_t'(rdata_raw);
  // A slot link that was never written reads as the reset free chain.
  assign rd_link = rvld_r ? rdata.link : def_link(ridx_r);

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign sum     = {1'b0, in_tdata[65:2]} + {23'd0, in_tdata[107:66]};
  assign wake_c  = (slot_ok(qhead_r) && head_dl_r < host_r) ? head_dl_r : host_r;

  // Result port.
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_O_HOST) || (state_r == ST_E_OUT) ||
                 (state_r == ST_O_FINAL);
    out_tlast  = (state_r == ST_O_FINAL);
    out_tuser  = kind_r;
    out_tdata  = {6'd0, pend_r, chg_r, wake_r, 8'd0};
    if (state_r == ST_O_HOST) begin
      out_tuser = RK_FIRED;
    end else if (state_r == ST_E_OUT) begin
      out_tuser = RK_EXPIRED;
      out_tdata[7:0] = rdata.handle;
    end else if (state_r == ST_O_FINAL) begin
      out_tdata[7:0] = id_r;
    end
  end

  // Sequencer: next state, RAM access and register updates.
  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  now_nxt = now_r;  dl_nxt = dl_r;
    id_nxt = id_r;  qhead_nxt = qhead_r;  fhead_nxt = fhead_r;
    host_nxt = host_r;  armed_nxt = armed_r;  head_dl_nxt = head_dl_r;
    wake_nxt = wake_r;  chg_nxt = chg_r;  pend_nxt = pend_r;  fired_nxt = fired_r;
    cur_nxt = cur_r;  prev_nxt = prev_r;  slot_nxt = slot_r;  pop_nxt = pop_r;
    pdl_nxt = pdl_r;  phd_nxt = phd_r;  cnt_nxt = cnt_r;  kind_nxt = kind_r;
    vld_nxt = vld_r;
    we = 1'b0;  waddr = slot_r[IDX_W-1:0];  raddr = cur_r[IDX_W-1:0];
    wdata = '{deadline: dl_r, handle: id_r, link: cur_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tdata[1:0];
          now_nxt  = in_tdata[65:2];
          dl_nxt   = sum[64] ? ALL_ONES : sum[63:0];
          id_nxt   = in_tdata[115:108];
          kind_nxt = RK_STATUS;
          cur_nxt  = qhead_r;
          pop_nxt  = qhead_r;
          prev_nxt = NULL_LINK;
          cnt_nxt  = '0;
          fired_nxt = 1'b0;
          state_nxt = ST_WAKE;
          unique case (op_t'(in_tdata[1:0]))
            OP_POST: begin
              if (!slot_ok(fhead_r)) begin
                kind_nxt = RK_DROPPED;
              end else begin
                slot_nxt  = fhead_r;
                state_nxt = ST_P_FREE_RD;
              end
            end
            OP_HOST: begin
              id_nxt   = '0;
              host_nxt = {20'd0, in_tdata[159:116]} * 64'(US_PER_MS);
            end
            OP_TICK: begin
              id_nxt = '0;
              if (in_tdata[65:2] >= host_r) begin
                fired_nxt = 1'b1;
                host_nxt  = ALL_ONES;
              end
              state_nxt = ST_T_RD;
            end
            default: id_nxt = '0;
          endcase
        end
      end
      ST_P_FREE_RD: begin
        raddr = slot_r[IDX_W-1:0];
        state_nxt = ST_P_FREE;
      end
      ST_P_FREE: begin
        fhead_nxt = rd_link;
        state_nxt = ST_P_RD;
      end
      ST_P_RD: begin
        if (slot_ok(cur_r) && cnt_r < CNT_W'(QUEUE_DEPTH)) begin
          state_nxt = ST_P_CMP;
        end else begin
          state_nxt = ST_P_INS;
        end
      end
      ST_P_CMP: begin
        if (rdata.deadline <= dl_r) begin
          prev_nxt = cur_r;
          pdl_nxt  = rdata.deadline;
          phd_nxt  = rdata.handle;
          cur_nxt  = rd_link;
          cnt_nxt  = cnt_r + CNT_W'(1);
          state_nxt = ST_P_RD;
        end else begin
          state_nxt = ST_P_INS;
        end
      end
      ST_P_INS: begin
        // The new slot links to the first later task.
        we = 1'b1;
        vld_nxt[slot_r[IDX_W-1:0]] = 1'b1;
        kind_nxt = RK_POSTED;
        if (slot_ok(prev_r)) begin
          state_nxt = ST_P_LNK;
        end else begin
          qhead_nxt   = slot_r;
          head_dl_nxt = dl_r;
          state_nxt   = ST_WAKE;
        end
      end
      ST_P_LNK: begin
        we = 1'b1;
        waddr = prev_r[IDX_W-1:0];
        wdata = '{deadline: pdl_r, handle: phd_r, link: slot_r};
        vld_nxt[prev_r[IDX_W-1:0]] = 1'b1;
        state_nxt = ST_WAKE;
      end
      ST_T_RD: begin
        // Count due tasks without unlinking them yet.
        if (slot_ok(cur_r)) begin
          state_nxt = ST_T_CMP;
        end else begin
          qhead_nxt = cur_r;
          state_nxt = ST_WAKE;
        end
      end
      ST_T_CMP: begin
        if (cnt_r < CNT_W'(QUEUE_DEPTH) && rdata.deadline <= now_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          cur_nxt = rd_link;
          state_nxt = ST_T_RD;
        end else begin
          qhead_nxt   = cur_r;
          head_dl_nxt = rdata.deadline;
          state_nxt   = ST_WAKE;
        end
      end
      ST_WAKE: begin
        wake_nxt  = wake_c;
        chg_nxt   = (wake_c != armed_r);
        armed_nxt = wake_c;
        pend_nxt  = (host_r != ALL_ONES) || slot_ok(qhead_r);
        if (op_r == OP_TICK && fired_r) begin
          state_nxt = ST_O_HOST;
        end else if (op_r == OP_TICK && cnt_r != '0) begin
          state_nxt = ST_E_RD;
        end else begin
          state_nxt = ST_O_FINAL;
        end
      end
      ST_O_HOST: begin
        if (out_acc) begin
          state_nxt = (cnt_r != '0) ? ST_E_RD : ST_O_FINAL;
        end
      end
      ST_E_RD: begin
        raddr = pop_r[IDX_W-1:0];
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        // Return the expired slot to the free list once its result is taken.
        raddr = pop_r[IDX_W-1:0];
        if (out_acc) begin
          we = 1'b1;
          waddr = pop_r[IDX_W-1:0];
          wdata = '{deadline: rdata.deadline, handle: rdata.handle, link: fhead_r};
          vld_nxt[pop_r[IDX_W-1:0]] = 1'b1;
          fhead_nxt = pop_r;
          pop_nxt   = rd_link;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = (cnt_r == CNT_W'(1)) ? ST_O_FINAL : ST_E_RD;
        end
      end
      ST_O_FINAL: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      qhead_r <= NULL_LINK;
      fhead_r <= '0;
      host_r  <= ALL_ONES;
      armed_r <= ALL_ONES;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      qhead_r <= qhead_nxt;
      fhead_r <= fhead_nxt;
      host_r  <= host_nxt;
      armed_r <= armed_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  now_r <= now_nxt;  dl_r <= dl_nxt;  id_r <= id_nxt;
    head_dl_r <= head_dl_nxt;  wake_r <= wake_nxt;  chg_r <= chg_nxt;
    pend_r <= pend_nxt;  fired_r <= fired_nxt;  cur_r <= cur_nxt;
    prev_r <= prev_nxt;  slot_r <= slot_nxt;  pop_r <= pop_nxt;
    pdl_r <= pdl_nxt;  phd_r <= phd_nxt;  cnt_r <= cnt_nxt;  kind_r <= kind_nxt;
    rvld_r <= vld_r[raddr];
    ridx_r <= raddr;
  end

endmodule
`default_nettype wire
